@@ rtl/core/tto_pkg.sv @@
package tto_pkg;

  // Default sizes of the member table and the hold-back queue.
  localparam int unsigned MembersDef    = 8;
  localparam int unsigned QueueDepthDef = 16;

  // Field widths.
  localparam int unsigned FuncW = 2;
  localparam int unsigned MachW = 8;
  localparam int unsigned MboxW = 8;
  localparam int unsigned SecW  = 32;
  localparam int unsigned UsecW = 20;
  localparam int unsigned TagW  = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned DataW = 88;

  // Function codes on the input tuser.
  localparam logic [FuncW-1:0] FuncReg   = 2'd0;
  localparam logic [FuncW-1:0] FuncData  = 2'd1;
  localparam logic [FuncW-1:0] FuncStamp = 2'd2;

  // Result kinds on the output tuser.
  typedef enum logic [KindW-1:0] {
    KIND_RELEASED = 3'd0,
    KIND_NONE     = 3'd1,
    KIND_DROP     = 3'd2,
    KIND_ADDED    = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  // Classified operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_REG,
    OP_DATA,
    OP_STAMP,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [MachW-1:0] mach;
    logic [MboxW-1:0] mbox;
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
    logic [TagW-1:0]  tag;
  } item_t;

  // One held message.
  typedef struct packed {
    logic [MachW-1:0] mach;
    logic [MboxW-1:0] mbox;
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
    logic [TagW-1:0]  tag;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [MachW-1:0] mach;
    logic [MboxW-1:0] mbox;
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
    logic [TagW-1:0]  tag;
  } res_t;

  // True when stamp a is strictly later than stamp b.
  function automatic logic later(input logic [SecW-1:0] as, input logic [UsecW-1:0] au,
                                 input logic [SecW-1:0] bs, input logic [UsecW-1:0] bu);
    return (as > bs) || ((as == bs) && (au > bu));
  endfunction

endpackage

@@ rtl/core/tto_front.sv @@
module tto_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: src_machine, src_mailbox, stamp_sec, stamp_usec, payload_tag, zero fill
  input  logic [tto_pkg::DataW-1:0] s_axis_tdata,
  // tuser: func
  input  logic [tto_pkg::FuncW-1:0] s_axis_tuser,
  output logic                 item_vld_o,
  output tto_pkg::item_t       item_o,
  input  logic                 item_pop_i
);

  tto_pkg::item_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  tto_pkg::item_t item_in;

  // Unpack the fields and classify the function code of the incoming transfer.
  always_comb begin
    item_in.mach = s_axis_tdata[7:0];
    item_in.mbox = s_axis_tdata[15:8];
    item_in.sec  = s_axis_tdata[47:16];
    item_in.usec = s_axis_tdata[67:48];
    item_in.tag  = s_axis_tdata[83:68];
    case (s_axis_tuser)
      tto_pkg::FuncReg:   item_in.op = tto_pkg::OP_REG;
      tto_pkg::FuncData:  item_in.op = tto_pkg::OP_DATA;
      tto_pkg::FuncStamp: item_in.op = tto_pkg::OP_STAMP;
      default:            item_in.op = tto_pkg::OP_NONE;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_vld_o    = (cnt_q != 2'd0);
  assign item_o        = fifo_q[rd_ptr_q];

  // Two-entry queue between the front and the back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !item_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && item_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ rtl/core/tto_back.sv @@
module tto_back #(
  parameter int unsigned MEMBERS     = tto_pkg::MembersDef,
  parameter int unsigned QUEUE_DEPTH = tto_pkg::QueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_vld_i,
  input  tto_pkg::item_t            item_i,
  output logic                      item_pop_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: out_machine, out_mailbox, out_sec, out_usec, out_tag, zero fill
  output logic [tto_pkg::DataW-1:0] m_axis_tdata,
  // tuser: kind
  output logic [tto_pkg::KindW-1:0] m_axis_tuser,
  output logic                      m_axis_tlast
);

  localparam int unsigned MCW = $clog2(MEMBERS + 1);
  localparam int unsigned MIW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_INS_RD,
    S_INS_CMP,
    S_MIN,
    S_REL_RD,
    S_REL_CMP,
    S_FINISH
  } state_e;

  state_e         state_q;
  tto_pkg::item_t cur_q;
  tto_pkg::res_t  pend_q, out_q;
  logic           pend_vld_q, out_vld_q, out_last_q;
  logic [MCW-1:0] mcnt_q, idx_q;
  logic           ev_q;
  logic [tto_pkg::SecW-1:0]  es_q;
  logic [tto_pkg::UsecW-1:0] eu_q;
  logic [QAW-1:0] head_q;
  logic [QCW-1:0] qcnt_q, k_q;

  // Member table, read at one walking index.
  logic [tto_pkg::MachW-1:0] mem_mach_q [MEMBERS];
  logic [tto_pkg::MboxW-1:0] mem_mbox_q [MEMBERS];
  logic [tto_pkg::SecW-1:0]  mem_sec_q  [MEMBERS];
  logic [tto_pkg::UsecW-1:0] mem_usec_q [MEMBERS];

  // Hold-back queue memory, kept sorted as a ring from head_q.
  tto_pkg::entry_t q_mem [QUEUE_DEPTH];
  tto_pkg::entry_t rd_q;

  logic            slot_free, hit, walk_end, reg_ok;
  logic            rel_go, out_load;
  logic            id_we, st_we, q_we;
  logic [MIW-1:0]  m_widx, m_ridx;
  logic [tto_pkg::SecW-1:0]  st_sec;
  logic [tto_pkg::UsecW-1:0] st_usec;
  logic [QAW-1:0]  q_waddr, q_raddr;
  tto_pkg::entry_t q_wdata, cur_ent;
  tto_pkg::res_t   rel_res, ctl_res;

  // Ring address of the entry at an offset from the head.
  function automatic logic [QAW-1:0] qaddr(input logic [QAW-1:0] head,
                                           input logic [QCW-1:0] off);
    logic [QAW:0] s;
    s = {1'b0, head} + (QAW+1)'(off);
    if (s >= (QAW+1)'(QUEUE_DEPTH)) begin
      s = s - (QAW+1)'(QUEUE_DEPTH);
    end
    return s[QAW-1:0];
  endfunction

  function automatic tto_pkg::res_t ctl(input tto_pkg::kind_e k);
    tto_pkg::res_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  assign slot_free = !out_vld_q || m_axis_tready;
  assign m_ridx    = idx_q[MIW-1:0];
  assign walk_end  = (idx_q == mcnt_q);
  assign hit       = !walk_end && (mem_mach_q[m_ridx] == cur_q.mach)
                     && (mem_mbox_q[m_ridx] == cur_q.mbox);
  assign reg_ok    = (mcnt_q < MCW'(MEMBERS));
  assign item_pop_o = (state_q == S_IDLE) && item_vld_i;

  // The head entry is due for release, and out_load loads the output register.
  assign rel_go   = (state_q == S_REL_CMP)
                    && !tto_pkg::later(rd_q.sec, rd_q.usec, es_q, eu_q);
  assign out_load = slot_free && ((state_q == S_FINISH) || (rel_go && pend_vld_q));

  assign cur_ent = '{mach: cur_q.mach, mbox: cur_q.mbox, sec: cur_q.sec,
                     usec: cur_q.usec, tag: cur_q.tag};
  assign rel_res = '{kind: tto_pkg::KIND_RELEASED, mach: rd_q.mach, mbox: rd_q.mbox,
                     sec: rd_q.sec, usec: rd_q.usec, tag: rd_q.tag};
  assign ctl_res = pend_vld_q ? pend_q : ctl(tto_pkg::KIND_NONE);

  // Table and queue write strobes and addresses, and the queue read address.
  always_comb begin
    id_we   = 1'b0;
    st_we   = 1'b0;
    m_widx  = m_ridx;
    st_sec  = cur_q.sec;
    st_usec = cur_q.usec;
    q_we    = 1'b0;
    q_waddr = qaddr(head_q, k_q);
    q_wdata = cur_ent;
    q_raddr = head_q;
    case (state_q)
      S_IDLE: begin
        if (item_vld_i && item_i.op == tto_pkg::OP_REG && reg_ok) begin
          id_we   = 1'b1;
          st_we   = 1'b1;
          m_widx  = mcnt_q[MIW-1:0];
          st_sec  = '0;
          st_usec = '0;
        end
      end
      S_MATCH: begin
        st_we = hit;
      end
      S_INS_RD: begin
        q_raddr = qaddr(head_q, k_q - QCW'(1));
        q_we    = (k_q == '0);
      end
      S_INS_CMP: begin
        q_we = 1'b1;
        if (tto_pkg::later(rd_q.sec, rd_q.usec, cur_q.sec, cur_q.usec)) begin
          q_wdata = rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      mem_mach_q[m_widx] <= item_i.mach;
      mem_mbox_q[m_widx] <= item_i.mbox;
    end
    if (st_we) begin
      mem_sec_q[m_widx]  <= st_sec;
      mem_usec_q[m_widx] <= st_usec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    rd_q <= q_mem[q_raddr];
  end

  // Sequencer: registration, stamp update, insertion, earliest stamp, release.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      mcnt_q     <= '0;
      idx_q      <= '0;
      ev_q       <= 1'b0;
      es_q       <= '0;
      eu_q       <= '0;
      head_q     <= '0;
      qcnt_q     <= '0;
      k_q        <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_vld_i) begin
            cur_q <= item_i;
            idx_q <= '0;
            case (item_i.op)
              tto_pkg::OP_REG: begin
                pend_vld_q <= 1'b1;
                if (reg_ok) begin
                  mcnt_q <= mcnt_q + MCW'(1);
                  pend_q <= ctl(tto_pkg::KIND_ADDED);
                end else begin
                  pend_q <= ctl(tto_pkg::KIND_FULL);
                end
                state_q <= S_FINISH;
              end
              tto_pkg::OP_NONE: begin
                pend_vld_q <= 1'b0;
                state_q    <= S_FINISH;
              end
              default: begin
                pend_vld_q <= 1'b0;
                state_q    <= S_MATCH;
              end
            endcase
          end
        end
        S_MATCH: begin
          if (walk_end || hit) begin
            idx_q <= '0;
            ev_q  <= 1'b0;
            if (cur_q.op == tto_pkg::OP_DATA) begin
              if (qcnt_q == QCW'(QUEUE_DEPTH)) begin
                pend_q     <= ctl(tto_pkg::KIND_DROP);
                pend_vld_q <= 1'b1;
                state_q    <= S_MIN;
              end else begin
                k_q     <= qcnt_q;
                state_q <= S_INS_RD;
              end
            end else begin
              state_q <= S_MIN;
            end
          end else begin
            idx_q <= idx_q + MCW'(1);
          end
        end
        S_INS_RD: begin
          if (k_q == '0) begin
            qcnt_q  <= qcnt_q + QCW'(1);
            state_q <= S_MIN;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (tto_pkg::later(rd_q.sec, rd_q.usec, cur_q.sec, cur_q.usec)) begin
            k_q     <= k_q - QCW'(1);
            state_q <= S_INS_RD;
          end else begin
            qcnt_q  <= qcnt_q + QCW'(1);
            state_q <= S_MIN;
          end
        end
        S_MIN: begin
          if (walk_end) begin
            state_q <= ev_q ? S_REL_RD : S_FINISH;
          end else begin
            if (mem_sec_q[m_ridx] != '0 && (!ev_q || tto_pkg::later(es_q, eu_q,
                mem_sec_q[m_ridx], mem_usec_q[m_ridx]))) begin
              es_q <= mem_sec_q[m_ridx];
              eu_q <= mem_usec_q[m_ridx];
              ev_q <= 1'b1;
            end
            idx_q <= idx_q + MCW'(1);
          end
        end
        S_REL_RD: begin
          state_q <= (qcnt_q == '0) ? S_FINISH : S_REL_CMP;
        end
        S_REL_CMP: begin
          if (!rel_go) begin
            state_q <= S_FINISH;
          end else if (!pend_vld_q || slot_free) begin
            if (pend_vld_q) begin
              out_q      <= pend_q;
              out_last_q <= 1'b0;
            end
            pend_q     <= rel_res;
            pend_vld_q <= 1'b1;
            head_q     <= qaddr(head_q, QCW'(1));
            qcnt_q     <= qcnt_q - QCW'(1);
            state_q    <= S_REL_RD;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_q      <= ctl_res;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0, out_q.tag, out_q.usec, out_q.sec, out_q.mbox, out_q.mach};

endmodule

@@ rtl/core/timestamp_total_order_queue_core.sv @@
// Hold-back queue that releases group messages in total timestamp order.
// Input channel s_axis: tuser carries the function (register member, data
// message, stamp-only message), tdata the sender, the stamp and the body tag.
// Output channel m_axis: tuser carries the result kind, tdata the released
// message, tlast marks the final result of one input transfer.
// Each input gives one or more results; a register input gives a single
// result. A message input walks the member table for the sender, shifts
// the queue memory back one entry at a time to insert a data message,
// walks the table again for the earliest stamp and then reads the queue
// head once per released message; one input is worked on at a time,
// behind a two-entry input queue.
// Reset empties the member table and the queue; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before the next result; input is still taken until the
// input queue is full.
module timestamp_total_order_queue_core #(
  parameter int unsigned MEMBERS     = tto_pkg::MembersDef,
  parameter int unsigned QUEUE_DEPTH = tto_pkg::QueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: src_machine, src_mailbox, stamp_sec, stamp_usec, payload_tag, zero fill
  input  logic [tto_pkg::DataW-1:0] s_axis_tdata,
  // tuser: func
  input  logic [tto_pkg::FuncW-1:0] s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: out_machine, out_mailbox, out_sec, out_usec, out_tag, zero fill
  output logic [tto_pkg::DataW-1:0] m_axis_tdata,
  // tuser: kind
  output logic [tto_pkg::KindW-1:0] m_axis_tuser,
  output logic                      m_axis_tlast
);

  logic           item_vld, item_pop;
  tto_pkg::item_t item;

  tto_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .item_vld_o (item_vld),
    .item_o     (item),
    .item_pop_i (item_pop)
  );

  tto_back #(
    .MEMBERS     (MEMBERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_vld_i (item_vld),
    .item_i     (item),
    .item_pop_o (item_pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

@@ rtl/core/tto_checker.sv @@
module tto_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [tto_pkg::DataW-1:0] s_axis_tdata,
  input logic [tto_pkg::FuncW-1:0] s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tto_pkg::DataW-1:0] m_axis_tdata,
  input logic [tto_pkg::KindW-1:0] m_axis_tuser,
  input logic                      m_axis_tlast
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // Only released messages carry message fields.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != tto_pkg::KIND_RELEASED |-> m_axis_tdata == '0)
    else $error("nonzero data on a status result");

  // Status results that stand alone close their input.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tto_pkg::KIND_NONE || m_axis_tuser == tto_pkg::KIND_ADDED
    || m_axis_tuser == tto_pkg::KIND_FULL) |-> m_axis_tlast)
    else $error("status result not marked last");

  // Result kinds stay within the defined codes.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= tto_pkg::KIND_FULL)
    else $error("undefined result kind");

endmodule

bind timestamp_total_order_queue_core tto_checker u_tto_checker (.*);

@@ tb/tb_timestamp_total_order_queue_core.sv @@
`timescale 1ns / 1ps

module tb_timestamp_total_order_queue_core;

  localparam int unsigned NumMembers = tto_pkg::MembersDef;
  localparam int unsigned NumSlots   = tto_pkg::QueueDepthDef;
  localparam logic [tto_pkg::FuncW-1:0] FuncUnused = 2'd3;
  localparam longint      CycleLimit = 2000000;

  typedef struct {
    tto_pkg::kind_e            kind;
    logic [tto_pkg::MachW-1:0] mach;
    logic [tto_pkg::MboxW-1:0] mbox;
    logic [tto_pkg::SecW-1:0]  sec;
    logic [tto_pkg::UsecW-1:0] usec;
    logic [tto_pkg::TagW-1:0]  tag;
    logic                      last;
  } outcome_t;

  typedef struct {
    logic [tto_pkg::MachW-1:0] mach;
    logic [tto_pkg::MboxW-1:0] mbox;
    logic [tto_pkg::SecW-1:0]  sec;
    logic [tto_pkg::UsecW-1:0] usec;
    logic [tto_pkg::TagW-1:0]  tag;
  } held_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [tto_pkg::DataW-1:0] s_axis_tdata;
  logic [tto_pkg::FuncW-1:0] s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [tto_pkg::DataW-1:0] m_axis_tdata;
  logic [tto_pkg::KindW-1:0] m_axis_tuser;
  logic                      m_axis_tlast;

  // Predictor state: member table and hold-back queue.
  logic [tto_pkg::MachW-1:0] grp_mach [NumMembers];
  logic [tto_pkg::MboxW-1:0] grp_mbox [NumMembers];
  logic [tto_pkg::SecW-1:0]  grp_sec  [NumMembers];
  logic [tto_pkg::UsecW-1:0] grp_usec [NumMembers];
  int unsigned               grp_count;
  held_t                     holdq[$];

  outcome_t    pending_results[$];
  int unsigned error_count;
  longint      cycle_count;
  bit          send_gaps;
  bit          sink_stalls;

  timestamp_total_order_queue_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit is_later(logic [tto_pkg::SecW-1:0] as, logic [tto_pkg::UsecW-1:0] au,
                                  logic [tto_pkg::SecW-1:0] bs, logic [tto_pkg::UsecW-1:0] bu);
    return (as > bs) || ((as == bs) && (au > bu));
  endfunction

  function automatic outcome_t plain(tto_pkg::kind_e kind);
    outcome_t o;
    o = '{kind: kind, mach: '0, mbox: '0, sec: '0, usec: '0, tag: '0, last: 1'b0};
    return o;
  endfunction

  // Works out the results of one item and updates the predicted state.
  task automatic predict_order(logic [tto_pkg::FuncW-1:0] func,
                               logic [tto_pkg::MachW-1:0] mach,
                               logic [tto_pkg::MboxW-1:0] mbox,
                               logic [tto_pkg::SecW-1:0] sec,
                               logic [tto_pkg::UsecW-1:0] usec,
                               logic [tto_pkg::TagW-1:0] tag);
    outcome_t    res[$];
    outcome_t    o;
    held_t       keep[$];
    held_t       h;
    int unsigned pos;
    bit          found;
    logic [tto_pkg::SecW-1:0]  es;
    logic [tto_pkg::UsecW-1:0] eu;
    if (func == tto_pkg::FuncReg) begin
      if (grp_count < NumMembers) begin
        grp_mach[grp_count] = mach;
        grp_mbox[grp_count] = mbox;
        grp_sec[grp_count]  = '0;
        grp_usec[grp_count] = '0;
        grp_count++;
        res = {res, plain(tto_pkg::KIND_ADDED)};
      end else begin
        res = {res, plain(tto_pkg::KIND_FULL)};
      end
    end else if (func == FuncUnused) begin
      res = {res, plain(tto_pkg::KIND_NONE)};
    end else begin
      // The first matching member takes the stamp.
      for (int i = 0; i < grp_count; i++) begin
        if (grp_mach[i] == mach && grp_mbox[i] == mbox) begin
          grp_sec[i]  = sec;
          grp_usec[i] = usec;
          break;
        end
      end
      if (func == tto_pkg::FuncData) begin
        if (holdq.size() >= NumSlots) begin
          res = {res, plain(tto_pkg::KIND_DROP)};
        end else begin
          pos = 0;
          while (pos < holdq.size() &&
                 !is_later(holdq[pos].sec, holdq[pos].usec, sec, usec)) pos++;
          h = '{mach: mach, mbox: mbox, sec: sec, usec: usec, tag: tag};
          holdq.insert(pos, h);
        end
      end
      // Earliest stamp among members that have one.
      found = 1'b0;
      es = '0;
      eu = '0;
      for (int i = 0; i < grp_count; i++) begin
        if (grp_sec[i] != 0 && (!found || is_later(es, eu, grp_sec[i], grp_usec[i]))) begin
          es = grp_sec[i];
          eu = grp_usec[i];
          found = 1'b1;
        end
      end
      if (found) begin
        foreach (holdq[i]) begin
          if (!is_later(holdq[i].sec, holdq[i].usec, es, eu)) begin
            o = '{kind: tto_pkg::KIND_RELEASED, mach: holdq[i].mach, mbox: holdq[i].mbox,
                  sec: holdq[i].sec, usec: holdq[i].usec, tag: holdq[i].tag, last: 1'b0};
            res = {res, o};
          end else begin
            keep = {keep, holdq[i]};
          end
        end
        holdq = keep;
      end
      if (res.size() == 0) res = {res, plain(tto_pkg::KIND_NONE)};
    end
    res[res.size()-1].last = 1'b1;
    pending_results = {pending_results, res};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Sends one item, predicting its results when the transfer happens.
  task automatic send_item(logic [tto_pkg::FuncW-1:0] func,
                           logic [tto_pkg::MachW-1:0] mach,
                           logic [tto_pkg::MboxW-1:0] mbox,
                           logic [tto_pkg::SecW-1:0] sec,
                           logic [tto_pkg::UsecW-1:0] usec,
                           logic [tto_pkg::TagW-1:0] tag);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= tto_pkg::DataW'({tag, usec, sec, mbox, mach});
    do @(posedge clk_i); while (!s_axis_tready);
    predict_order(func, mach, mbox, sec, usec, tag);
  endtask

  // Idles the input and waits until every expected result has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Output side: random stalls and the result check.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_axis_tuser), 64'd0);
        end else begin
          outcome_t w;
          w = pending_results.pop_front();
          if (m_axis_tuser != w.kind)
            report_mismatch("kind", 64'(m_axis_tuser), 64'(w.kind));
          if (m_axis_tdata[7:0] != w.mach)
            report_mismatch("machine", 64'(m_axis_tdata[7:0]), 64'(w.mach));
          if (m_axis_tdata[15:8] != w.mbox)
            report_mismatch("mailbox", 64'(m_axis_tdata[15:8]), 64'(w.mbox));
          if (m_axis_tdata[47:16] != w.sec)
            report_mismatch("sec", 64'(m_axis_tdata[47:16]), 64'(w.sec));
          if (m_axis_tdata[67:48] != w.usec)
            report_mismatch("usec", 64'(m_axis_tdata[67:48]), 64'(w.usec));
          if (m_axis_tdata[83:68] != w.tag)
            report_mismatch("tag", 64'(m_axis_tdata[83:68]), 64'(w.tag));
          if (m_axis_tlast != w.last)
            report_mismatch("last", 64'(m_axis_tlast), 64'(w.last));
        end
      end
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        // Transfers cannot happen while ready is low, so nothing is missed.
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("tb_timestamp_total_order_queue_core: done, errors");
        $finish;
      end
    end
  end

  // Registration, table full, duplicates, unused function code.
  task automatic test_membership();
    send_item(FuncUnused, 8'hFF, 8'hFF, '1, 20'hFFFFF, '1);
    send_item(tto_pkg::FuncStamp, 8'd1, 8'd1, 32'd5, 20'd0, 16'd0);
    send_item(tto_pkg::FuncData, 8'd1, 8'd1, 32'd5, 20'd0, 16'hAAAA);
    for (int i = 0; i < NumMembers - 1; i++)
      send_item(tto_pkg::FuncReg, 8'(i), 8'(i), 32'd0, 20'd0, 16'd0);
    send_item(tto_pkg::FuncReg, 8'd0, 8'd0, 32'd0, 20'd0, 16'd0);
    send_item(tto_pkg::FuncReg, 8'hFF, 8'hFF, '1, 20'hFFFFF, '1);
  endtask

  // Ordering, stamp reset by zero, extreme fields, queue full.
  task automatic test_ordering();
    send_item(tto_pkg::FuncData, 8'd0, 8'd0, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF);
    send_item(tto_pkg::FuncData, 8'd9, 8'd9, 32'd3, 20'd999999, 16'h0001);
    send_item(tto_pkg::FuncStamp, 8'd0, 8'd0, 32'd0, 20'd0, 16'd0);
    for (int i = 0; i < NumSlots + 2; i++)
      send_item(tto_pkg::FuncData, 8'd77, 8'd77, 32'd100 - 32'(i % 3),
                20'($urandom_range(0, 3)), 16'(i));
    wait_drained();
    // Each member that can match stamps late enough to flush the queue; the duplicate entry never matches.
    for (int i = 0; i < NumMembers - 1; i++)
      send_item(tto_pkg::FuncStamp, 8'(i), 8'(i), '1, 20'hFFFFF, 16'd0);
    send_item(tto_pkg::FuncStamp, 8'hFF, 8'hFF, '1, 20'hFFFFF, 16'd0);
    send_item(tto_pkg::FuncStamp, 8'd0, 8'd0, '1, 20'hFFFFF, 16'd0);
  endtask

  // Random traffic, mostly from registered members, with mostly nearby stamps.
  task automatic test_random_traffic(int unsigned count);
    logic [tto_pkg::FuncW-1:0] func;
    int unsigned m;
    logic [7:0] mach;
    logic [7:0] mbox;
    logic [31:0] sec;
    logic [19:0] usec;
    for (int n = 0; n < count; n++) begin
      m = $urandom_range(0, 9);
      if (m < NumMembers) begin
        mach = 8'(m);
        mbox = 8'(m);
      end else begin
        mach = 8'($urandom);
        mbox = 8'($urandom);
      end
      case ($urandom_range(0, 19))
        0: func = tto_pkg::FuncReg;
        1: func = FuncUnused;
        2, 3, 4, 5, 6, 7: func = tto_pkg::FuncStamp;
        default: func = tto_pkg::FuncData;
      endcase
      case ($urandom_range(0, 9))
        0: sec = 32'd0;
        1: sec = $urandom;
        default: sec = 32'hFFFFFF00 + $urandom_range(0, 40);
      endcase
      usec = 20'($urandom_range(0, 3)) + (($urandom_range(0, 3) == 0) ? 20'hFFFFC : 20'd0);
      send_item(func, mach, mbox, sec, usec, 16'($urandom));
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    error_count   = 0;
    send_gaps     = 1'b1;
    sink_stalls   = 1'b1;
    grp_count     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_membership();
    test_ordering();
    test_random_traffic(240);
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(60);
    wait_drained();
    if (error_count == 0) begin
      $display("tb_timestamp_total_order_queue_core: done, clean");
    end else begin
      $display("tb_timestamp_total_order_queue_core: done, errors");
    end
    $finish;
  end

endmodule
